[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tssg_pkg.sv]
// ----------------------------------------------------------------------------
// tssg_pkg
// Shared types and constants for the triangle span generator.
// ----------------------------------------------------------------------------
package tssg_pkg;

  // Row coordinate width inside a tile
  localparam int YW = 6;

  typedef logic [YW-1:0] row_t;

  // Vertex rows after sorting
  typedef struct packed {
    row_t top;
    row_t mid;
    row_t bot;
  } rows_t;

  // Status of the triangle queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/triangle_scanline_span_generator.sv]
// A triangle's first span follows its edge divisions and an init step.
// Each triangle is paced by the one-bit-per-cycle edge dividers, then by
// one span per cycle while the output register is free or popped.
// A two-entry triangle queue lets new input in while spans drain.
// Reset (rst, synchronous) empties the queue and output; no clearing pass.
// ----------------------------------------------------------------------------
// triangle_scanline_span_generator
// Splits a triangle into one horizontal span per row, top to bottom.
// ----------------------------------------------------------------------------
module triangle_scanline_span_generator #(
  parameter int TILE_ROWS = 64,
  parameter int X_BITS    = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [X_BITS-1:0]        first_x,
  input  logic [tssg_pkg::YW-1:0]  first_y,
  input  logic [X_BITS-1:0]        second_x,
  input  logic [tssg_pkg::YW-1:0]  second_y,
  input  logic [X_BITS-1:0]        third_x,
  input  logic [tssg_pkg::YW-1:0]  third_y,
  output logic                     empty,
  input  logic                     pop,
  output logic [tssg_pkg::YW-1:0]  span_row,
  output logic [X_BITS-1:0]        span_left,
  output logic [X_BITS-1:0]        span_right,
  output logic                     span_last
);

  localparam int QW = 3 * X_BITS + $bits(tssg_pkg::rows_t);

  tssg_pkg::q_stat_t       q_stat;
  logic                    q_push;
  logic                    q_pop;
  logic [2:0][X_BITS-1:0]  f_xs;
  tssg_pkg::rows_t         f_rows;
  logic [2:0][X_BITS-1:0]  b_xs;
  tssg_pkg::rows_t         b_rows;
  logic [QW-1:0]           q_dout;

  // Sort and classify
  tssg_front #(.TILE_ROWS(TILE_ROWS), .X_BITS(X_BITS)) u_front (
    .push     (push),
    .full     (full),
    .first_x  (first_x),
    .first_y  (first_y),
    .second_x (second_x),
    .second_y (second_y),
    .third_x  (third_x),
    .third_y  (third_y),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_xs     (f_xs),
    .q_rows   (f_rows)
  );

  // Triangle queue
  tssg_fifo #(.W(QW)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .din  ({f_xs, f_rows}),
    .rd   (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  assign {b_xs, b_rows} = q_dout;

  // Span engine
  tssg_back #(.X_BITS(X_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .q_xs       (b_xs),
    .q_rows     (b_rows),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .span_row   (span_row),
    .span_left  (span_left),
    .span_right (span_right),
    .span_last  (span_last)
  );

endmodule

[rtl/core/tssg_front.sv]
// ----------------------------------------------------------------------------
// tssg_front
// Input side: clamps rows, sorts the vertices by row and queues triangles
// with nonzero height. Flat triangles are accepted and dropped here.
// ----------------------------------------------------------------------------
module tssg_front #(
  parameter int TILE_ROWS = 64,
  parameter int X_BITS    = 10
) (
  input  logic                            push,
  output logic                            full,
  input  logic [X_BITS-1:0]               first_x,
  input  logic [tssg_pkg::YW-1:0]         first_y,
  input  logic [X_BITS-1:0]               second_x,
  input  logic [tssg_pkg::YW-1:0]         second_y,
  input  logic [X_BITS-1:0]               third_x,
  input  logic [tssg_pkg::YW-1:0]         third_y,
  input  tssg_pkg::q_stat_t               q_stat,
  output logic                            q_push,
  output logic [2:0][X_BITS-1:0]          q_xs,
  output tssg_pkg::rows_t                 q_rows
);

  localparam tssg_pkg::row_t ROW_SAT = tssg_pkg::row_t'(TILE_ROWS - 1);

  logic [2:0][X_BITS-1:0]   xs;
  tssg_pkg::row_t [2:0]     ys;

  function automatic tssg_pkg::row_t clamp_row(input tssg_pkg::row_t y);
    clamp_row = (int'(y) > TILE_ROWS - 1) ? ROW_SAT : y;
  endfunction

  // Three compare-and-swap stages; swap only on strictly greater
  always_comb begin
    logic [X_BITS-1:0] tx;
    tssg_pkg::row_t    ty;
    tx    = '0;
    ty    = '0;
    xs[0] = first_x;
    xs[1] = second_x;
    xs[2] = third_x;
    ys[0] = clamp_row(first_y);
    ys[1] = clamp_row(second_y);
    ys[2] = clamp_row(third_y);
    if (ys[0] > ys[1]) begin
      tx = xs[0]; ty = ys[0];
      xs[0] = xs[1]; ys[0] = ys[1];
      xs[1] = tx; ys[1] = ty;
    end
    if (ys[1] > ys[2]) begin
      tx = xs[1]; ty = ys[1];
      xs[1] = xs[2]; ys[1] = ys[2];
      xs[2] = tx; ys[2] = ty;
    end
    if (ys[0] > ys[1]) begin
      tx = xs[0]; ty = ys[0];
      xs[0] = xs[1]; ys[0] = ys[1];
      xs[1] = tx; ys[1] = ty;
    end
  end

  // Queue write: zero-height triangles produce no spans
  assign full        = q_stat.full;
  assign q_push      = push && !q_stat.full && (ys[2] != ys[0]);
  assign q_xs        = xs;
  assign q_rows.top  = ys[0];
  assign q_rows.mid  = ys[1];
  assign q_rows.bot  = ys[2];

endmodule

[rtl/core/tssg_fifo.sv]
// ----------------------------------------------------------------------------
// tssg_fifo
// Two-entry queue of sorted triangles between front and back.
// ----------------------------------------------------------------------------
module tssg_fifo #(
  parameter int W = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  logic [W-1:0]      din,
  input  logic              rd,
  output logic [W-1:0]      dout,
  output tssg_pkg::q_stat_t stat
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  assign dout       = mem[rptr];
  assign stat.full  = count[1];
  assign stat.empty = (count == 2'd0);

endmodule

[rtl/core/tssg_back.sv]
// ----------------------------------------------------------------------------
// tssg_back
// Span engine: divides each edge delta by its height (three restoring
// lanes, one bit per cycle), then walks the rows with exact integer DDA
// steps and drives one span per cycle, while the output register is free or popped.
// ----------------------------------------------------------------------------
module tssg_back #(
  parameter int X_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tssg_pkg::q_stat_t        q_stat,
  input  logic [2:0][X_BITS-1:0]   q_xs,
  input  tssg_pkg::rows_t          q_rows,
  output logic                     q_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic [tssg_pkg::YW-1:0]  span_row,
  output logic [X_BITS-1:0]        span_left,
  output logic [X_BITS-1:0]        span_right,
  output logic                     span_last
);

  localparam int YW = tssg_pkg::YW;
  localparam int CW = $clog2(X_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_INIT = 4'b0100,
    S_RUN  = 4'b1000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [2:0][X_BITS-1:0]    xs;
  tssg_pkg::row_t            ytop;
  tssg_pkg::row_t [2:0]      hgt;      // long, upper, lower
  logic [2:0]                neg;
  logic [2:0][X_BITS-1:0]    quo;
  tssg_pkg::row_t [2:0]      rem;
  logic [2:0][X_BITS-1:0]    quo_next;
  tssg_pkg::row_t [2:0]      rem_next;
  logic [CW-1:0]             cnt;
  logic [2:0][X_BITS-1:0]    stp;      // floor(dx / h), mod 2^X_BITS
  tssg_pkg::row_t [2:0]      srem;     // dx mod h
  logic [X_BITS-1:0]         long_q;
  tssg_pkg::row_t            long_r;
  logic [X_BITS-1:0]         short_q;
  tssg_pkg::row_t            short_r;
  tssg_pkg::row_t            idx;
  logic                      out_valid;
  logic                      adv;
  logic                      last;
  logic                      second;
  logic [X_BITS+YW-1:0]      long_nx;
  logic [X_BITS+YW-1:0]      up_nx;
  logic [X_BITS+YW-1:0]      lo_nx;

  // One DDA step: q += s, r += sr, carry into q when r reaches h
  function automatic logic [X_BITS+YW-1:0] edge_step(
    input logic [X_BITS-1:0] q,
    input tssg_pkg::row_t    r,
    input logic [X_BITS-1:0] s,
    input tssg_pkg::row_t    sr,
    input tssg_pkg::row_t    h
  );
    logic [YW:0] sum;
    sum = {1'b0, r} + {1'b0, sr};
    if (sum >= {1'b0, h}) begin
      edge_step = {q + s + X_BITS'(1), YW'(sum - {1'b0, h})};
    end else begin
      edge_step = {q + s, sum[YW-1:0]};
    end
  endfunction

  // Restoring divider step for each lane
  always_comb begin
    logic [YW:0] rsh;
    for (int l = 0; l < 3; l++) begin
      rsh = {rem[l], quo[l][X_BITS-1]};
      if (rsh >= {1'b0, hgt[l]}) begin
        rem_next[l] = YW'(rsh - {1'b0, hgt[l]});
        quo_next[l] = {quo[l][X_BITS-2:0], 1'b1};
      end else begin
        rem_next[l] = rsh[YW-1:0];
        quo_next[l] = {quo[l][X_BITS-2:0], 1'b0};
      end
    end
  end

  // Row walk control
  assign adv     = (state == S_RUN) && (!out_valid || pop);
  assign last    = (tssg_pkg::row_t'(idx + 1'b1) == hgt[0]);
  assign second  = (idx > hgt[1]) || (hgt[1] == '0);
  assign q_pop   = (state == S_IDLE) && !q_stat.empty;
  assign long_nx = edge_step(long_q, long_r, stp[0], srem[0], hgt[0]);
  assign up_nx   = edge_step(short_q, short_r, stp[1], srem[1], hgt[1]);
  assign lo_nx   = edge_step(short_q, short_r, stp[2], srem[2], hgt[2]);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_pop) state_next = S_DIV;
      S_DIV:  if (cnt == CW'(1)) state_next = S_INIT;
      S_INIT: state_next = S_RUN;
      S_RUN:  if (adv && last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          xs     <= q_xs;
          ytop   <= q_rows.top;
          hgt[0] <= q_rows.bot - q_rows.top;
          hgt[1] <= q_rows.mid - q_rows.top;
          hgt[2] <= q_rows.bot - q_rows.mid;
          neg[0] <= q_xs[2] < q_xs[0];
          neg[1] <= q_xs[1] < q_xs[0];
          neg[2] <= q_xs[2] < q_xs[1];
          quo[0] <= (q_xs[2] < q_xs[0]) ? q_xs[0] - q_xs[2] : q_xs[2] - q_xs[0];
          quo[1] <= (q_xs[1] < q_xs[0]) ? q_xs[0] - q_xs[1] : q_xs[1] - q_xs[0];
          quo[2] <= (q_xs[2] < q_xs[1]) ? q_xs[1] - q_xs[2] : q_xs[2] - q_xs[1];
          rem    <= '0;
          cnt    <= CW'(X_BITS);
        end
      end
      S_DIV: begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt - CW'(1);
      end
      S_INIT: begin
        // Turn |dx| div h into floor division of the signed delta
        for (int l = 0; l < 3; l++) begin
          if (neg[l] && (rem[l] != '0)) begin
            stp[l]  <= ~quo[l];
            srem[l] <= hgt[l] - rem[l];
          end else if (neg[l]) begin
            stp[l]  <= ~quo[l] + X_BITS'(1);
            srem[l] <= '0;
          end else begin
            stp[l]  <= quo[l];
            srem[l] <= rem[l];
          end
        end
        long_q  <= xs[0];
        long_r  <= '0;
        short_q <= (hgt[1] == '0) ? xs[1] : xs[0];
        short_r <= '0;
        idx     <= '0;
      end
      S_RUN: begin
        if (adv) begin
          span_row   <= ytop + idx;
          span_left  <= (long_q < short_q) ? long_q : short_q;
          span_right <= (long_q < short_q) ? short_q : long_q;
          span_last  <= last;
          {long_q, long_r} <= long_nx;
          if (second) begin
            {short_q, short_r} <= lo_nx;
          end else if (idx == hgt[1]) begin
            // Middle vertex reached: restart on the lower edge at k = 1
            short_q <= xs[1] + stp[2];
            short_r <= srem[2];
          end else begin
            {short_q, short_r} <= up_nx;
          end
          idx <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign empty = !out_valid;

endmodule

[rtl/core/tssg_checker.sv]
// ----------------------------------------------------------------------------
// tssg_checker
// Port-level checks on the span generator, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tssg_checker #(
  parameter int X_BITS = 10
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     full,
  input logic                     empty,
  input logic                     pop,
  input logic [tssg_pkg::YW-1:0]  span_row,
  input logic [X_BITS-1:0]        span_left,
  input logic [X_BITS-1:0]        span_right,
  input logic                     span_last
);

  // Reset leaves the triangle queue open and the output empty
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> empty && !full, "not empty/open after reset")

  // A span waiting on the output holds still
  `ASSERT_CLK(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(span_row) && $stable(span_left) && $stable(span_right) && $stable(span_last)), "span changed while stalled")

  // Spans come out ordered
  `ASSERT_CLK(a_order, clk, rst, !empty |-> span_left <= span_right, "left beyond right")

  // Inside a triangle the next row follows on the very next cycle
  `ASSERT_CLK(a_next_row, clk, rst, (!empty && pop && !span_last) |=> (!empty && span_row == $past(span_row) + 6'd1), "row sequence broken")

endmodule

bind triangle_scanline_span_generator tssg_checker #(.X_BITS(X_BITS)) u_tssg_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .span_row   (span_row),
  .span_left  (span_left),
  .span_right (span_right),
  .span_last  (span_last)
);

[bench/tb_triangle_scanline_span_generator.sv]
// ----------------------------------------------------------------------------
// tb_triangle_scanline_span_generator
// Self-checking bench for the triangle span generator. A directed set of
// triangles (flat, flat top, flat bottom, ties, full tile height, vertex
// permutations) is followed by random triangles. Each accepted triangle is
// rasterized here into its expected spans. Every popped span is compared
// field by field against the oldest expected span. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_triangle_scanline_span_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int X_BITS        = 10;
  localparam int TILE_ROWS     = 64;
  localparam int N_RANDOM      = 88;
  localparam int SETTLE_CYCLES = 100;

  typedef tssg_pkg::row_t row_t;
  typedef logic [X_BITS-1:0] xcoord_t;

  typedef struct packed {
    xcoord_t x;
    row_t    y;
  } vertex_t;

  typedef struct packed {
    vertex_t one;
    vertex_t two;
    vertex_t three;
  } triangle_t;

  typedef struct packed {
    row_t    row;
    xcoord_t left;
    xcoord_t right;
    logic    last;
  } span_t;

  // Block inputs, known from time zero
  logic    clk      = 1'b0;
  logic    rst      = 1'b1;
  logic    push     = 1'b0;
  logic    pop      = 1'b0;
  xcoord_t first_x  = '0;
  row_t    first_y  = '0;
  xcoord_t second_x = '0;
  row_t    second_y = '0;
  xcoord_t third_x  = '0;
  row_t    third_y  = '0;

  logic    full;
  logic    empty;
  row_t    span_row;
  xcoord_t span_left;
  xcoord_t span_right;
  logic    span_last;

  // Stimulus and expectation stores
  triangle_t   triangles_to_send[$];
  span_t       expected_spans[$];
  triangle_t   cur_triangle;
  int unsigned triangles_sent = 0;
  int unsigned triangles_total = 0;
  int unsigned flat_triangles = 0;
  int unsigned spans_checked = 0;
  int unsigned errors = 0;
  int unsigned push_gap = 0;
  int unsigned pop_stall = 0;
  logic        push_burst = 1'b0;
  logic        pop_burst = 1'b0;
  logic        next_push;
  logic        next_pop;

  triangle_scanline_span_generator #(
    .TILE_ROWS (TILE_ROWS),
    .X_BITS    (X_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .first_x    (first_x),
    .first_y    (first_y),
    .second_x   (second_x),
    .second_y   (second_y),
    .third_x    (third_x),
    .third_y    (third_y),
    .empty      (empty),
    .pop        (pop),
    .span_row   (span_row),
    .span_left  (span_left),
    .span_right (span_right),
    .span_last  (span_last)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // Exact floor of xs + (xe - xs) * k / h, h > 0, 0 <= k <= h
  function automatic xcoord_t interp_x(input int unsigned xs, input int unsigned xe,
                                       input int unsigned k, input int unsigned h);
    longint num;
    num = longint'(xs) * longint'(h) + (longint'(xe) - longint'(xs)) * longint'(k);
    if (num < 0) num = 0;
    return xcoord_t'(num / longint'(h));
  endfunction

  // Sort vertices by row (stable swap network) and queue one span per row
  task automatic rasterize_triangle(input triangle_t t);
    vertex_t     v[3];
    vertex_t     tmp;
    int unsigned height;
    int unsigned upper;
    int unsigned lower;
    xcoord_t     long_x;
    xcoord_t     short_x;
    span_t       s;
    v[0] = t.one;
    v[1] = t.two;
    v[2] = t.three;
    if (v[0].y > v[1].y) begin
      tmp = v[0]; v[0] = v[1]; v[1] = tmp;
    end
    if (v[1].y > v[2].y) begin
      tmp = v[1]; v[1] = v[2]; v[2] = tmp;
    end
    if (v[0].y > v[1].y) begin
      tmp = v[0]; v[0] = v[1]; v[1] = tmp;
    end
    height = v[2].y - v[0].y;
    upper  = v[1].y - v[0].y;
    lower  = v[2].y - v[1].y;
    if (height == 0) flat_triangles++;
    for (int unsigned i = 0; i < height; i++) begin
      long_x = interp_x(v[0].x, v[2].x, i, height);
      // middle row still belongs to the top half
      if (i > upper || upper == 0)
        short_x = interp_x(v[1].x, v[2].x, i - upper, lower);
      else
        short_x = interp_x(v[0].x, v[1].x, i, upper);
      s.row   = row_t'(v[0].y + i);
      s.left  = (long_x < short_x) ? long_x : short_x;
      s.right = (long_x < short_x) ? short_x : long_x;
      s.last  = (i + 1 == height);
      expected_spans.push_back(s);
    end
  endtask

  function automatic triangle_t make_triangle(input int ax, input int ay, input int bx,
                                              input int by, input int cx, input int cy);
    triangle_t t;
    t.one   = '{x: xcoord_t'(ax), y: row_t'(ay)};
    t.two   = '{x: xcoord_t'(bx), y: row_t'(by)};
    t.three = '{x: xcoord_t'(cx), y: row_t'(cy)};
    return t;
  endfunction

  // Random triangle: mostly free, some with tied rows, short or flat
  function automatic triangle_t random_triangle();
    triangle_t   t;
    int unsigned kind;
    int unsigned base;
    t.one   = '{x: xcoord_t'($urandom), y: row_t'($urandom)};
    t.two   = '{x: xcoord_t'($urandom), y: row_t'($urandom)};
    t.three = '{x: xcoord_t'($urandom), y: row_t'($urandom)};
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      t.two.y = t.one.y;
    end else if (kind < 5) begin
      t.three.y = t.two.y;
    end else if (kind < 6) begin
      t.three.y = t.one.y;
    end else if (kind < 8) begin
      base = $urandom_range(0, 59);
      t.one.y   = row_t'(base + $urandom_range(0, 4));
      t.two.y   = row_t'(base + $urandom_range(0, 4));
      t.three.y = row_t'(base + $urandom_range(0, 4));
    end else if (kind < 9) begin
      t.two.y   = t.one.y;
      t.three.y = t.one.y;
    end
    return t;
  endfunction

  // Driver: one triangle per transfer, random gap after each
  always @(posedge clk) begin
    if (rst) begin
      push     <= 1'b0;
      push_gap = 0;
    end else begin
      next_push = push;
      if (push && !full) begin
        rasterize_triangle(cur_triangle);
        triangles_sent++;
        next_push = 1'b0;
        if ($urandom_range(0, 7) == 0) push_burst = ~push_burst;
        push_gap = push_burst ? 0 : $urandom_range(0, 19);
      end
      if (!next_push) begin
        if (push_gap != 0) begin
          push_gap--;
        end else if (triangles_to_send.size() != 0) begin
          cur_triangle = triangles_to_send.pop_front();
          first_x   <= cur_triangle.one.x;
          first_y   <= cur_triangle.one.y;
          second_x  <= cur_triangle.two.x;
          second_y  <= cur_triangle.two.y;
          third_x   <= cur_triangle.three.x;
          third_y   <= cur_triangle.three.y;
          next_push = 1'b1;
        end
      end
      push <= next_push;
    end
  end

  // Monitor: pop spans with random stalls and compare
  always @(posedge clk) begin
    if (rst) begin
      pop       <= 1'b0;
      pop_stall = 0;
    end else begin
      next_pop = pop;
      if (pop && !empty) begin
        if (expected_spans.size() == 0) begin
          report_mismatch($sformatf("span row %0d [%0d,%0d] last %0b with none expected",
                                    span_row, span_left, span_right, span_last));
        end else begin
          span_t exp_span;
          exp_span = expected_spans.pop_front();
          if (span_row !== exp_span.row)
            report_mismatch($sformatf("span_row got %0d exp %0d", span_row, exp_span.row));
          if (span_left !== exp_span.left)
            report_mismatch($sformatf("span_left got %0d exp %0d (row %0d)",
                                      span_left, exp_span.left, exp_span.row));
          if (span_right !== exp_span.right)
            report_mismatch($sformatf("span_right got %0d exp %0d (row %0d)",
                                      span_right, exp_span.right, exp_span.row));
          if (span_last !== exp_span.last)
            report_mismatch($sformatf("span_last got %0b exp %0b (row %0d)",
                                      span_last, exp_span.last, exp_span.row));
        end
        spans_checked++;
        next_pop = 1'b0;
        if ($urandom_range(0, 31) == 0) pop_burst = ~pop_burst;
        pop_stall = pop_burst ? 0 : $urandom_range(0, 19);
      end
      if (!next_pop) begin
        if (pop_stall != 0) pop_stall--;
        else next_pop = 1'b1;
      end
      pop <= next_pop;
    end
  end

  // Stimulus and end of run
  initial begin
    // flat triangles, nothing expected
    triangles_to_send.push_back(make_triangle(100, 20, 500, 20, 900, 20));
    triangles_to_send.push_back(make_triangle(0, 0, 0, 0, 0, 0));
    // full tile height, x extremes
    triangles_to_send.push_back(make_triangle(0, 0, 1023, 63, 512, 31));
    triangles_to_send.push_back(make_triangle(1023, 63, 0, 0, 1023, 0));
    // flat top and flat bottom
    triangles_to_send.push_back(make_triangle(0, 10, 1023, 10, 512, 40));
    triangles_to_send.push_back(make_triangle(512, 5, 0, 40, 1023, 40));
    // reverse row order at the input
    triangles_to_send.push_back(make_triangle(300, 50, 700, 30, 100, 10));
    // tied rows keep input order
    triangles_to_send.push_back(make_triangle(10, 30, 900, 30, 500, 0));
    triangles_to_send.push_back(make_triangle(900, 30, 10, 30, 500, 0));
    triangles_to_send.push_back(make_triangle(500, 30, 10, 0, 900, 0));
    // single row and short triangles around the middle row
    triangles_to_send.push_back(make_triangle(5, 7, 1000, 8, 600, 7));
    triangles_to_send.push_back(make_triangle(0, 0, 1023, 2, 0, 4));
    triangles_to_send.push_back(make_triangle(0, 62, 1023, 63, 1023, 63));
    triangles_to_send.push_back(make_triangle(1023, 0, 1023, 63, 1023, 32));
    // alternating bit patterns
    triangles_to_send.push_back(make_triangle(682, 21, 341, 42, 1023, 63));
    triangles_to_send.push_back(make_triangle(341, 42, 682, 21, 0, 0));
    // every vertex order of one triangle
    triangles_to_send.push_back(make_triangle(100, 3, 800, 12, 400, 25));
    triangles_to_send.push_back(make_triangle(100, 3, 400, 25, 800, 12));
    triangles_to_send.push_back(make_triangle(800, 12, 100, 3, 400, 25));
    triangles_to_send.push_back(make_triangle(800, 12, 400, 25, 100, 3));
    triangles_to_send.push_back(make_triangle(400, 25, 100, 3, 800, 12));
    triangles_to_send.push_back(make_triangle(400, 25, 800, 12, 100, 3));
    for (int i = 0; i < N_RANDOM; i++)
      triangles_to_send.push_back(random_triangle());
    triangles_total = triangles_to_send.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (triangles_sent < triangles_total) @(posedge clk);
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_spans.size() != 0)
      report_mismatch($sformatf("%0d spans never arrived", expected_spans.size()));

    $display("Sent %0d triangles (%0d flat), checked %0d spans, %0d errors.",
             triangles_total, flat_triangles, spans_checked, errors);
    if (errors == 0) begin
      $display("triangle_scanline_span_generator: match");
    end else begin
      $display("triangle_scanline_span_generator: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("triangle_scanline_span_generator: mismatch");
    $finish;
  end

endmodule
